// ===== hdl/snapshot_frame_checker_core_defines.svh =====
// ----------------------------------------------------------------------------
// snapshot frame checker assertion macros
// concurrent check helpers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_FRAME_CHECKER_CORE_DEFINES_SVH
`define SNAPSHOT_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define SFC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SFC_ASSERT(lbl, prop, msg)
`define SFC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hdl/snap_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// snapshot frame checker package
// verdict codes, header layout, fnv-1a 64 constants and hash step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snap_chk_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned HDR_CNT_W = 5;

    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // verdict codes, in check order after ok
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SMALL    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAGIC   = 1'b0,
        CFG_VERSION = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] version;
        logic [63:0] hash;
        status_t     status;
    } verdict_t;

    // one fnv-1a 64 step: xor the byte in, multiply by 2^40 + 0x1b3 mod 2^64
    // 0x1b3 has bits 0, 1, 4, 5, 7 and 8 set, so the product is a sum of shifts
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

// ===== hdl/snap_chk_frame.sv =====
// ----------------------------------------------------------------------------
// snapshot frame checker frame state
// header capture, payload hash and verdict for the item being processed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "snapshot_frame_checker_core_defines.svh"

module snap_chk_frame
    import snap_chk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] magic_word,
    input  logic [31:0] expected_version,
    output verdict_t    verdict
);

    logic [HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]          magic_reg, magic_next;
    logic [31:0]          version_reg, version_next;
    logic [63:0]          csum_reg, csum_next;
    logic [63:0]          hash_reg, hash_next;
    logic                 hdr_done;

    assign hdr_done = hdr_cnt_reg[HDR_CNT_W-1];

    // state after this byte
    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        csum_next    = csum_reg;
        hash_next    = hash_reg;
        hdr_cnt_next = hdr_cnt_reg;
        if (hdr_done)
        begin
            hash_next = fnv_step(hash_reg, data_byte);
        end
        else
        begin
            hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
            unique case (hdr_cnt_reg[3:2])
                2'd0:    magic_next[8*hdr_cnt_reg[1:0] +: 8]   = data_byte;
                2'd1:    version_next[8*hdr_cnt_reg[1:0] +: 8] = data_byte;
                default: csum_next[8*hdr_cnt_reg[2:0] +: 8]    = data_byte;
            endcase
        end
    end

    // verdict on the updated state
    always_comb
    begin
        verdict.hash    = hash_next;
        verdict.version = version_next;
        priority if (!hdr_cnt_next[HDR_CNT_W-1])
        begin
            verdict.status  = ST_SMALL;
            verdict.version = '0;
        end
        else if (magic_next != magic_word)
            verdict.status = ST_MAGIC;
        else if (version_next != expected_version)
            verdict.status = ST_VERSION;
        else if (hash_next != csum_next)
            verdict.status = ST_CHECKSUM;
        else
            verdict.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
            magic_reg   <= '0;
            version_reg <= '0;
            csum_reg    <= '0;
            hash_reg    <= FNV_BASIS;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                hdr_cnt_reg <= '0;
                magic_reg   <= '0;
                version_reg <= '0;
                csum_reg    <= '0;
                hash_reg    <= FNV_BASIS;
            end
            else
            begin
                hdr_cnt_reg <= hdr_cnt_next;
                magic_reg   <= magic_next;
                version_reg <= version_next;
                csum_reg    <= csum_next;
                hash_reg    <= hash_next;
            end
        end
    end

    `SFC_ASSERT_NEVER(a_hdr_cnt_range, hdr_cnt_reg > HDR_CNT_W'(HDR_BYTES), "header count overran")
    `SFC_ASSERT(a_hash_idle_in_hdr, !hdr_done |-> hash_reg == FNV_BASIS, "hash moved during header")
    `SFC_ASSERT(a_clear_after_last, step && last_byte |=> hdr_cnt_reg == '0 && hash_reg == FNV_BASIS, "frame state not cleared")

endmodule

// ===== hdl/snapshot_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// snapshot frame checker core
// validates a byte-serial frame: 16-byte header, fnv-1a 64 over the payload
// ----------------------------------------------------------------------------
// The block takes one frame byte per item on the slave stream, tlast marking
// the final byte. Bytes 0..3 are the magic word, 4..7 the version and 8..15
// the checksum, all little-endian; every later byte is folded into an
// fnv-1a 64 hash. On the last byte one verdict item leaves on the master
// stream: ok, too small, bad magic, bad version or checksum mismatch, tested
// in that order, along with the payload hash and the header version (zero
// when the frame is too small). The frame state then clears for the next
// frame. Throughput is one byte per cycle unless the slave side stalls;
// the combinational hash step is xor plus a shift-and-add multiply by the
// fnv prime. The verdict register loads as the held last byte moves on.
// The slave side only stalls when a held last byte sits behind a waiting
// verdict and the master side holds tready low. Configuration writes are
// always accepted and must only happen while no frame is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "snapshot_frame_checker_core_defines.svh"

module snapshot_frame_checker_core
    import snap_chk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,  // 0 magic_word, 1 expected_version
    input  logic [31:0]  cfg_data,
    // frame bytes in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic         s_tlast,    // last_byte
    // verdict out
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata     // [2:0] status, [66:3] computed_hash,
                                     // [98:67] frame_version, rest zero
);

    // configuration registers
    logic [31:0] magic_word_reg;
    logic [31:0] exp_version_reg;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // result stage
    logic        out_valid_reg;
    verdict_t    out_reg;

    logic        advance;
    logic        load;
    verdict_t    verdict;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg  <= '0;
            exp_version_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MAGIC:   magic_word_reg  <= cfg_data;
                CFG_VERSION: exp_version_reg <= cfg_data;
            endcase
        end
    end

    // the held item moves on unless it is a last byte and the verdict
    // register is full and not being drained this cycle
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign load     = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // header capture, payload hash and verdict
    snap_chk_frame u_frame (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .data_byte        (in_byte_reg),
        .last_byte        (in_last_reg),
        .magic_word       (magic_word_reg),
        .expected_version (exp_version_reg),
        .verdict          (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= verdict;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.version, out_reg.hash, out_reg.status};

    `SFC_ASSERT(a_load_sets_valid, load |=> out_valid_reg, "verdict lost on load")
    `SFC_ASSERT(a_stall_cause,
        in_valid_reg && !advance |-> in_last_reg && out_valid_reg && !m_tready,
        "input stalled without a full verdict register")
    `SFC_ASSERT(a_small_fields,
        out_valid_reg && out_reg.status == ST_SMALL |->
            out_reg.version == '0 && out_reg.hash == FNV_BASIS,
        "short frame verdict carries payload fields")

endmodule

// ===== test/frame_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// frame verdict checker
// watches the config, byte and verdict channels, predicts each verdict and
// compares it field by field with what the block sends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_verdict_checker
    import snap_chk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           errors,
    output int           pending
);

    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

    logic [31:0] magic_cfg;
    logic [31:0] version_cfg;
    logic [4:0]  hdr_taken;
    logic [31:0] magic_got;
    logic [31:0] version_got;
    logic [63:0] sum_got;
    logic [63:0] digest;
    verdict_t    verdicts_due[$];

    task automatic clear_frame();
        hdr_taken   = '0;
        magic_got   = '0;
        version_got = '0;
        sum_got     = '0;
        digest      = FNV_BASIS;
    endtask

    // header bytes fill the fields, payload bytes go into the hash
    task automatic fold_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        if (hdr_taken < HDR_BYTES)
        begin
            if (hdr_taken < 4)
                magic_got[8*hdr_taken +: 8] = b;
            else if (hdr_taken < 8)
                version_got[8*(hdr_taken-4) +: 8] = b;
            else
                sum_got[8*(hdr_taken-8) +: 8] = b;
            hdr_taken = hdr_taken + 5'd1;
        end
        else
        begin
            digest = (digest ^ {56'd0, b}) * FNV_PRIME;
        end
        if (last)
        begin
            v.hash    = digest;
            v.version = version_got;
            if (hdr_taken < HDR_BYTES)
            begin
                v.status  = ST_SMALL;
                v.version = '0;
            end
            else if (magic_got != magic_cfg)
                v.status = ST_MAGIC;
            else if (version_got != version_cfg)
                v.status = ST_VERSION;
            else if (digest != sum_got)
                v.status = ST_CHECKSUM;
            else
                v.status = ST_OK;
            verdicts_due.push_back(v);
            clear_frame();
        end
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endtask

    task automatic check_verdict(input logic [103:0] word);
        verdict_t got;
        verdict_t want;
        got = word[98:0];
        if (verdicts_due.size() == 0)
        begin
            errors++;
            $display("%0t: verdict with none due, expected nothing actual %h", $time, word);
        end
        else
        begin
            want = verdicts_due.pop_front();
            if (got.status !== want.status)
                note_mismatch("status", 64'(want.status), 64'(got.status));
            if (got.hash !== want.hash)
                note_mismatch("computed_hash", want.hash, got.hash);
            if (got.version !== want.version)
                note_mismatch("frame_version", 64'(want.version), 64'(got.version));
            if (word[103:99] !== '0)
                note_mismatch("padding", 64'd0, 64'(word[103:99]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_cfg   = '0;
            version_cfg = '0;
            errors      = 0;
            verdicts_due.delete();
            clear_frame();
        end
        else
        begin
            // older verdicts first, so a same-edge last byte cannot mask one
            if (m_tvalid && m_tready)
                check_verdict(m_tdata);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAGIC)
                    magic_cfg = cfg_data;
                else
                    version_cfg = cfg_data;
            end
            if (s_tvalid && s_tready)
                fold_byte(s_tdata, s_tlast);
        end
        pending = verdicts_due.size();
    end

endmodule

// ===== test/tb_snapshot_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// snapshot frame checker testbench
// builds good and broken frames over several register settings, with random
// gaps on the byte stream and random backpressure on the verdict stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_snapshot_frame_checker_core;
    import snap_chk_pkg::*;

    localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01b3;
    localparam int          STALL_LIMIT = 2000;
    localparam int          PHASES      = 6;
    localparam int          PHASE_BYTES = 300;

    typedef logic [7:0] byte_q_t[$];

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    int          errors;
    int          pending;
    int          quiet_cycles = 0;
    int          phase_bytes;
    bit          calm;          // no idling on either side while set
    logic [31:0] cur_magic;
    logic [31:0] cur_version;

    snapshot_frame_checker_core i_dut (.*);

    frame_verdict_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // fnv-1a 64 over the payload, used only to build frames with good checksums
    function automatic logic [63:0] payload_digest(input byte_q_t body);
        logic [63:0] h;
        h = FNV_BASIS;
        foreach (body[i])
            h = (h ^ {56'd0, body[i]}) * FNV_PRIME;
        return h;
    endfunction

    // called at a falling edge; returns at the falling edge after the item
    // is taken, with tvalid still high so the next item can follow directly
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // header little-endian, then payload; a nonzero cut truncates the frame
    task automatic send_frame(input logic [31:0] mg, input logic [31:0] vr,
                              input logic [63:0] ck, input byte_q_t body, input int cut);
        byte_q_t bytes;
        int      n;
        for (int i = 0; i < 4; i++)
            bytes.push_back(mg[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            bytes.push_back(vr[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            bytes.push_back(ck[8*i +: 8]);
        foreach (body[i])
            bytes.push_back(body[i]);
        n = (cut > 0) ? cut : bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(bytes[i], i == n - 1);
        phase_bytes += n;
    endtask

    // mostly well-formed frames matching the registers, the rest broken
    task automatic random_frame();
        byte_q_t     body;
        logic [31:0] mg;
        logic [31:0] vr;
        logic [63:0] ck;
        int          plen;
        int          pick;
        int          cut;
        calm = ($urandom_range(0, 3) == 0);
        // short payloads keep frames frequent, a few long ones stress the hash
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
        repeat (plen)
            body.push_back(8'($urandom));
        mg   = cur_magic;
        vr   = cur_version;
        ck   = payload_digest(body);
        cut  = 0;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            mg ^= 32'd1 << $urandom_range(0, 31);
        else if (pick < 16)
            vr ^= 32'd1 << $urandom_range(0, 31);
        else if (pick < 26)
            ck ^= 64'd1 << $urandom_range(0, 63);
        else if (pick < 32)
        begin
            // version error must win over the checksum error
            vr ^= 32'd1 << $urandom_range(0, 31);
            ck ^= 64'd1 << $urandom_range(0, 63);
        end
        else if (pick < 42)
            cut = $urandom_range(1, 15);
        else if (pick < 47)
        begin
            // noise header
            mg = $urandom;
            vr = $urandom;
            ck = {$urandom, $urandom};
        end
        send_frame(mg, vr, ck, body, cut);
    endtask

    // both registers back to back, channel lowered once at the end
    task automatic program_regs(input logic [31:0] mg, input logic [31:0] vr);
        cur_magic   = mg;
        cur_version = vr;
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAGIC;
        cfg_data  <= mg;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= CFG_VERSION;
        cfg_data  <= vr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // main stimulus
    initial
    begin
        byte_q_t none;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MAGIC;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        calm      = 1'b0;
        phase_bytes = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       program_regs(32'h0, 32'h0);
                1:       program_regs(32'hffff_ffff, 32'hffff_ffff);
                2:       program_regs(32'hffff_ffff, 32'h0);
                3:       program_regs(32'h0, 32'hffff_ffff);
                default: program_regs($urandom, $urandom);
            endcase

            if (phase == 0)
            begin
                // single byte frame is too small; header-only frame with the
                // offset basis as checksum passes
                send_frame(32'hff, 32'h0, 64'h0, none, 1);
                send_frame(32'h0, 32'h0, FNV_BASIS, none, 0);
            end

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                random_frame();

            // every phase ends on a last byte; drain, then let the pipe settle
            s_tvalid <= 1'b0;
            calm = 1'b0;
            while (pending != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end

        repeat (8) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_snapshot_frame_checker_core: clean");
        else
            $display("tb_snapshot_frame_checker_core: errors");
        $finish;
    end

    // verdict side backpressure: random stalls between runs of ready
    initial
    begin
        int stall;
        int run;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(negedge clk);
        end
    end

    // watchdog: too long without any item moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_snapshot_frame_checker_core: errors");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/snap_chk_pkg.sv
hdl/snap_chk_frame.sv
hdl/snapshot_frame_checker_core.sv
test/frame_verdict_checker.sv
test/tb_snapshot_frame_checker_core.sv
